### rtl/i2cmr_pkg.sv
// i2cmr_pkg: shared types and constants for the i2c register-read master
// used by i2cmr_core and i2c_master_command_read; no dependencies
package i2cmr_pkg;

  // upper bound on bytes read in one transaction
  localparam int MAX_READ_BYTES = 16;

  localparam logic [15:0] DELAY_RESET = 16'd200;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_DELAY_TICKS    = 1'b1;

  // bus segment currently being driven
  typedef enum logic [4:0] {
    P_IDLE, P_S0, P_S1, P_S2, P_S3,
    P_WB0, P_WB1, P_WB2, P_WA0, P_WA1, P_WA2,
    P_RB0, P_RB1, P_RA0, P_RA1, P_RA2,
    P_SP0, P_SP1, P_SP2
  } phase_t;

  // which part of the transaction is in progress
  typedef enum logic [2:0] {
    ST_ADDR_W, ST_CMD, ST_ADDR_R, ST_READ, ST_STOP
  } stage_t;

  // one result per tick
  typedef struct packed {
    logic       status_1;
    logic       status_0;
    logic       done_res;
    logic       last_byte;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

### rtl/i2c_master_command_read.sv
// i2c_master_command_read: top level of the i2c register-read master
// depends on i2cmr_pkg and i2cmr_core
//
// usage: every request on the s_ channel is one tick of bus timing. it carries
// start_req, the command byte, the read length and the sampled sda level. the
// block answers each request with exactly one result on the m_ channel: the
// scl/sda drive levels for that tick, busy, a completed read byte with its
// valid flag and last marker (tlast), the done pulse after stop, and status.
// a start is taken only while idle; the sequence is start, address+write,
// command, repeated start, address+read, the read bytes (ack on all but the
// last) and stop, each bus segment lasting delay_ticks requests (one if zero).
// latency: the result of a request appears in the output register on the
// cycle after it is accepted. throughput: one request per cycle while the
// result channel is not stalled; the whole tick update is one pass of logic
// from the sequencer registers into the output register.
// stall: s_tready follows m_tready whenever a result is held, so a stalled
// receiver holds the pending result and new requests wait; nothing is lost.
// reset: sequencer idle, pins released, status 0, delay_ticks 200, address 0,
// output register empty.
module i2c_master_command_read (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // start_req, command[7:0], read_length[4:0], sda_in, pad
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level, sda_level, busy_res, byte_valid,
                                 // read_byte[7:0], done_res, status[1:0], pad
  output logic        m_tlast,   // last_byte
  // configuration write port
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]          device_address;
  logic [15:0]         delay_ticks;
  logic                in_fire;
  i2cmr_pkg::result_t  res;
  i2cmr_pkg::result_t  out_res;
  logic                out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
      delay_ticks    <= i2cmr_pkg::DELAY_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        i2cmr_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        i2cmr_pkg::CFG_DELAY_TICKS:    delay_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a new request is taken whenever the output register is free or draining
  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  i2cmr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (in_fire),
    .start_req      (s_tdata[0]),
    .command        (s_tdata[8:1]),
    .read_length    (s_tdata[13:9]),
    .sda_in         (s_tdata[14]),
    .device_address (device_address),
    .delay_ticks    (delay_ticks),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.last_byte;
  assign m_tdata  = {1'b0, out_res.status_1, out_res.status_0, out_res.done_res,
                     out_res.read_byte, out_res.byte_valid, out_res.busy_res,
                     out_res.sda_level, out_res.scl_level};

  // a read byte or a done pulse only occurs inside a transaction
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.byte_valid) |-> out_res.busy_res)
    else $error("read byte reported outside a transaction");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.done_res) |-> (out_res.busy_res && out_res.scl_level
                                         && out_res.sda_level))
    else $error("done without released bus inside a transaction");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> out_res.byte_valid)
    else $error("last marker without a read byte");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.byte_valid) |-> (out_res.read_byte == 8'd0))
    else $error("read byte nonzero without valid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending straight after reset");

endmodule

### rtl/i2cmr_core.sv
// i2cmr_core: bus sequencer state and the single-tick next-state logic
// depends on i2cmr_pkg
module i2cmr_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               start_req,
  input  logic [7:0]         command,
  input  logic [4:0]         read_length,
  input  logic               sda_in,
  input  logic [6:0]         device_address,
  input  logic [15:0]        delay_ticks,
  output i2cmr_pkg::result_t res
);

  localparam logic [4:0] MAX_LEN = 5'(i2cmr_pkg::MAX_READ_BYTES);

  i2cmr_pkg::phase_t phase, phase_next, cur_phase;
  i2cmr_pkg::stage_t stage, stage_next, cur_stage;
  logic [15:0] tick_count, tick_count_next, cur_tick;
  logic [2:0]  bit_index, bit_index_next, cur_bit;
  logic [7:0]  shift_byte, shift_byte_next, cur_shift;
  logic [4:0]  byte_index, byte_index_next, cur_byte;
  logic [7:0]  held_command, held_command_next, cur_cmd;
  logic [4:0]  held_length, held_length_next, cur_len;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic [1:0]  status_reg, status_reg_next, cur_status;
  logic [4:0]  len_clamped;
  logic [15:0] span;
  logic        seg_end;
  logic        ack_bit;
  logic [4:0]  byte_inc;
  logic        valid;
  logic [7:0]  rbyte;
  logic        last;
  logic        done;

  always_comb begin
    len_clamped = (read_length == 5'd0) ? 5'd1 : read_length;
    if (len_clamped > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end
  end

  // effective state for this tick, with a fresh start folded in
  always_comb begin
    cur_phase  = phase;
    cur_stage  = stage;
    cur_tick   = tick_count;
    cur_bit    = bit_index;
    cur_shift  = shift_byte;
    cur_byte   = byte_index;
    cur_cmd    = held_command;
    cur_len    = held_length;
    cur_status = status_reg;
    if (phase == i2cmr_pkg::P_IDLE && start_req) begin
      cur_phase  = i2cmr_pkg::P_S0;
      cur_stage  = i2cmr_pkg::ST_ADDR_W;
      cur_tick   = '0;
      cur_bit    = '0;
      cur_shift  = '0;
      cur_byte   = '0;
      cur_cmd    = command;
      cur_len    = len_clamped;
      cur_status = '0;
    end
  end

  assign span     = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
  assign seg_end  = ({1'b0, cur_tick} + 17'd1) >= {1'b0, span};
  assign byte_inc = cur_byte + 5'd1;
  assign ack_bit  = ({1'b0, cur_byte} + 6'd1 < {1'b0, cur_len}) ? 1'b0 : 1'b1;

  // pin drive for the current segment
  always_comb begin
    scl_reg_next = scl_reg;
    sda_reg_next = sda_reg;
    case (cur_phase)
      i2cmr_pkg::P_S0:  sda_reg_next = 1'b1;
      i2cmr_pkg::P_S1:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_S2:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b0; end
      i2cmr_pkg::P_S3:  begin scl_reg_next = 1'b0; sda_reg_next = 1'b0; end
      i2cmr_pkg::P_WB0: begin scl_reg_next = 1'b0; sda_reg_next = cur_shift[7]; end
      i2cmr_pkg::P_WB1: begin scl_reg_next = 1'b1; sda_reg_next = cur_shift[7]; end
      i2cmr_pkg::P_WB2: begin scl_reg_next = 1'b0; sda_reg_next = cur_shift[7]; end
      i2cmr_pkg::P_WA0: begin scl_reg_next = 1'b0; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_WA1: begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_WA2: begin scl_reg_next = 1'b0; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_RB0: begin scl_reg_next = 1'b0; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_RB1: begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
      i2cmr_pkg::P_RA0: begin scl_reg_next = 1'b0; sda_reg_next = ack_bit; end
      i2cmr_pkg::P_RA1: begin scl_reg_next = 1'b1; sda_reg_next = ack_bit; end
      i2cmr_pkg::P_RA2: begin scl_reg_next = 1'b0; sda_reg_next = ack_bit; end
      i2cmr_pkg::P_SP0: sda_reg_next = 1'b0;
      i2cmr_pkg::P_SP1: begin scl_reg_next = 1'b1; sda_reg_next = 1'b0; end
      i2cmr_pkg::P_SP2: begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
      default: ;
    endcase
  end

  // segment sequencing
  always_comb begin
    phase_next        = cur_phase;
    stage_next        = cur_stage;
    tick_count_next   = cur_tick;
    bit_index_next    = cur_bit;
    shift_byte_next   = cur_shift;
    byte_index_next   = cur_byte;
    held_command_next = cur_cmd;
    held_length_next  = cur_len;
    status_reg_next   = cur_status;
    valid             = 1'b0;
    rbyte             = '0;
    last              = 1'b0;
    done              = 1'b0;
    if (cur_phase != i2cmr_pkg::P_IDLE) begin
      if (!seg_end) begin
        tick_count_next = cur_tick + 16'd1;
      end else begin
        tick_count_next = '0;
        case (cur_phase)
          i2cmr_pkg::P_S0: phase_next = i2cmr_pkg::P_S1;
          i2cmr_pkg::P_S1: phase_next = i2cmr_pkg::P_S2;
          i2cmr_pkg::P_S2: phase_next = i2cmr_pkg::P_S3;
          i2cmr_pkg::P_S3: begin
            shift_byte_next = {device_address, cur_stage == i2cmr_pkg::ST_ADDR_R};
            bit_index_next  = '0;
            phase_next      = i2cmr_pkg::P_WB0;
          end
          i2cmr_pkg::P_WB0: phase_next = i2cmr_pkg::P_WB1;
          i2cmr_pkg::P_WB1: phase_next = i2cmr_pkg::P_WB2;
          i2cmr_pkg::P_WB2: begin
            if (cur_bit == 3'd7) begin
              phase_next = i2cmr_pkg::P_WA0;
            end else begin
              bit_index_next  = cur_bit + 3'd1;
              shift_byte_next = {cur_shift[6:0], 1'b0};
              phase_next      = i2cmr_pkg::P_WB0;
            end
          end
          i2cmr_pkg::P_WA0: phase_next = i2cmr_pkg::P_WA1;
          i2cmr_pkg::P_WA1: begin
            // nack code follows the byte being written
            if (sda_in) begin
              status_reg_next = 2'(cur_stage) + 2'd1;
            end
            phase_next = i2cmr_pkg::P_WA2;
          end
          i2cmr_pkg::P_WA2: begin
            if (cur_status != 2'd0) begin
              stage_next = i2cmr_pkg::ST_STOP;
              phase_next = i2cmr_pkg::P_SP0;
            end else if (cur_stage == i2cmr_pkg::ST_ADDR_W) begin
              stage_next      = i2cmr_pkg::ST_CMD;
              shift_byte_next = cur_cmd;
              bit_index_next  = '0;
              phase_next      = i2cmr_pkg::P_WB0;
            end else if (cur_stage == i2cmr_pkg::ST_CMD) begin
              stage_next = i2cmr_pkg::ST_ADDR_R;
              phase_next = i2cmr_pkg::P_S0;
            end else begin
              stage_next      = i2cmr_pkg::ST_READ;
              byte_index_next = '0;
              shift_byte_next = '0;
              bit_index_next  = '0;
              phase_next      = i2cmr_pkg::P_RB0;
            end
          end
          i2cmr_pkg::P_RB0: phase_next = i2cmr_pkg::P_RB1;
          i2cmr_pkg::P_RB1: begin
            shift_byte_next = {cur_shift[6:0], sda_in};
            if (cur_bit == 3'd7) begin
              valid      = 1'b1;
              rbyte      = {cur_shift[6:0], sda_in};
              last       = ack_bit;
              phase_next = i2cmr_pkg::P_RA0;
            end else begin
              bit_index_next = cur_bit + 3'd1;
              phase_next     = i2cmr_pkg::P_RB0;
            end
          end
          i2cmr_pkg::P_RA0: phase_next = i2cmr_pkg::P_RA1;
          i2cmr_pkg::P_RA1: phase_next = i2cmr_pkg::P_RA2;
          i2cmr_pkg::P_RA2: begin
            byte_index_next = byte_inc;
            if (byte_inc < cur_len) begin
              shift_byte_next = '0;
              bit_index_next  = '0;
              phase_next      = i2cmr_pkg::P_RB0;
            end else begin
              stage_next = i2cmr_pkg::ST_STOP;
              phase_next = i2cmr_pkg::P_SP0;
            end
          end
          i2cmr_pkg::P_SP0: phase_next = i2cmr_pkg::P_SP1;
          i2cmr_pkg::P_SP1: phase_next = i2cmr_pkg::P_SP2;
          i2cmr_pkg::P_SP2: begin
            done       = 1'b1;
            phase_next = i2cmr_pkg::P_IDLE;
            stage_next = i2cmr_pkg::ST_ADDR_W;
          end
          default: phase_next = i2cmr_pkg::P_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res            = '0;
    res.scl_level  = scl_reg_next;
    res.sda_level  = sda_reg_next;
    res.busy_res   = (cur_phase != i2cmr_pkg::P_IDLE);
    res.byte_valid = valid;
    res.read_byte  = rbyte;
    res.last_byte  = last;
    res.done_res   = done;
    res.status_1   = status_reg_next[1];
    res.status_0   = status_reg_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cmr_pkg::P_IDLE;
      stage        <= i2cmr_pkg::ST_ADDR_W;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      byte_index   <= '0;
      held_command <= '0;
      held_length  <= 5'd1;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      status_reg   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      stage        <= stage_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      byte_index   <= byte_index_next;
      held_command <= held_command_next;
      held_length  <= held_length_next;
      scl_reg      <= scl_reg_next;
      sda_reg      <= sda_reg_next;
      status_reg   <= status_reg_next;
    end
  end

endmodule

### tb/sv/i2cmr_bus_checker.sv
// i2cmr_bus_checker: watches the request, result and configuration ports of
// i2c_master_command_read, predicts every bus tick and compares in order
// depends on i2cmr_pkg for the phase, stage and register index codes
module i2cmr_bus_checker
  import i2cmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // start_req, command[7:0], read_length[4:0], sda_in, pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // scl_level, sda_level, busy_res, byte_valid,
                                 // read_byte[7:0], done_res, status[1:0], pad
  input  logic        m_tlast,   // last_byte
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          bytes_checked,
  output int          transfers_ended,
  output int          nack_endings
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       valid;
    logic [7:0] rbyte;
    logic       last;
    logic       done;
    logic [1:0] status;
  } bus_tick_t;

  // shadow of the sequencer
  phase_t      phase;
  stage_t      stage;
  logic [15:0] tick_cnt;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  logic [4:0]  byte_idx;
  logic [7:0]  held_cmd;
  logic [4:0]  held_len;
  logic        scl_q;
  logic        sda_q;
  logic [1:0]  status_q;
  logic [6:0]  dev_addr;
  logic [15:0] delay_q;

  bus_tick_t   bus_tick_q[$];
  bus_tick_t   got;
  bus_tick_t   want;
  int          fail_n;
  int          result_n;
  int          byte_n;
  int          ended_n;
  int          nack_n;

  function automatic void load_byte(input logic [7:0] value);
    shreg   = value;
    bit_idx = '0;
    phase   = P_WB0;
  endfunction

  function automatic void open_read_byte();
    shreg   = '0;
    bit_idx = '0;
    phase   = P_RB0;
  endfunction

  // one tick of bus timing: pins for this tick, then segment bookkeeping
  function automatic bus_tick_t next_bus_tick(input logic start, input logic [7:0] cmd,
                                              input logic [4:0] len, input logic sda_in);
    bus_tick_t r;
    int        span;
    logic      bit_out;
    logic      ack;
    r    = '0;
    span = (delay_q == 16'd0) ? 1 : int'(delay_q);
    if (phase == P_IDLE && start) begin
      if (len == 5'd0) held_len = 5'd1;
      else if (int'(len) > MAX_READ_BYTES) held_len = 5'(MAX_READ_BYTES);
      else held_len = len;
      held_cmd = cmd;
      status_q = '0;
      stage    = ST_ADDR_W;
      byte_idx = '0;
      bit_idx  = '0;
      shreg    = '0;
      tick_cnt = '0;
      phase    = P_S0;
    end
    r.busy = (phase != P_IDLE);
    if (phase != P_IDLE) begin
      bit_out = shreg[7];
      ack     = (int'(byte_idx) + 1 < int'(held_len)) ? 1'b0 : 1'b1;
      case (phase)
        P_S0:  sda_q = 1'b1;
        P_S1:  {scl_q, sda_q} = 2'b11;
        P_S2:  {scl_q, sda_q} = 2'b10;
        P_S3:  {scl_q, sda_q} = 2'b00;
        P_WB0: {scl_q, sda_q} = {1'b0, bit_out};
        P_WB1: {scl_q, sda_q} = {1'b1, bit_out};
        P_WB2: {scl_q, sda_q} = {1'b0, bit_out};
        P_WA0: {scl_q, sda_q} = 2'b01;
        P_WA1: {scl_q, sda_q} = 2'b11;
        P_WA2: {scl_q, sda_q} = 2'b01;
        P_RB0: {scl_q, sda_q} = 2'b01;
        P_RB1: {scl_q, sda_q} = 2'b11;
        P_RA0: {scl_q, sda_q} = {1'b0, ack};
        P_RA1: {scl_q, sda_q} = {1'b1, ack};
        P_RA2: {scl_q, sda_q} = {1'b0, ack};
        P_SP0: sda_q = 1'b0;
        P_SP1: {scl_q, sda_q} = 2'b10;
        P_SP2: {scl_q, sda_q} = 2'b11;
        default: ;
      endcase
      if (int'(tick_cnt) + 1 >= span) begin
        tick_cnt = '0;
        case (phase)
          P_S0:  phase = P_S1;
          P_S1:  phase = P_S2;
          P_S2:  phase = P_S3;
          P_S3:  load_byte({dev_addr, stage == ST_ADDR_R});
          P_WB0: phase = P_WB1;
          P_WB1: phase = P_WB2;
          P_WB2: begin
            if (bit_idx >= 4'd7) begin
              phase = P_WA0;
            end else begin
              bit_idx = bit_idx + 4'd1;
              shreg   = shreg << 1;
              phase   = P_WB0;
            end
          end
          P_WA0: phase = P_WA1;
          P_WA1: begin
            if (sda_in) status_q = 2'(int'(stage) + 1);
            phase = P_WA2;
          end
          P_WA2: begin
            if (status_q != 2'd0) begin
              stage = ST_STOP;
              phase = P_SP0;
            end else if (stage == ST_ADDR_W) begin
              stage = ST_CMD;
              load_byte(held_cmd);
            end else if (stage == ST_CMD) begin
              stage = ST_ADDR_R;
              phase = P_S0;
            end else begin
              stage    = ST_READ;
              byte_idx = '0;
              open_read_byte();
            end
          end
          P_RB0: phase = P_RB1;
          P_RB1: begin
            shreg = {shreg[6:0], sda_in};
            if (bit_idx >= 4'd7) begin
              r.valid = 1'b1;
              r.rbyte = shreg;
              r.last  = (int'(byte_idx) + 1 >= int'(held_len));
              phase   = P_RA0;
            end else begin
              bit_idx = bit_idx + 4'd1;
              phase   = P_RB0;
            end
          end
          P_RA0: phase = P_RA1;
          P_RA1: phase = P_RA2;
          P_RA2: begin
            byte_idx = byte_idx + 5'd1;
            if (byte_idx < held_len) begin
              open_read_byte();
            end else begin
              stage = ST_STOP;
              phase = P_SP0;
            end
          end
          P_SP0: phase = P_SP1;
          P_SP1: phase = P_SP2;
          P_SP2: begin
            r.done = 1'b1;
            phase  = P_IDLE;
            stage  = ST_ADDR_W;
          end
          default: phase = P_IDLE;
        endcase
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    r.scl    = scl_q;
    r.sda    = sda_q;
    r.status = status_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase    = P_IDLE;
      stage    = ST_ADDR_W;
      tick_cnt = '0;
      bit_idx  = '0;
      shreg    = '0;
      byte_idx = '0;
      held_cmd = '0;
      held_len = 5'd1;
      scl_q    = 1'b1;
      sda_q    = 1'b1;
      status_q = '0;
      dev_addr = '0;
      delay_q  = DELAY_RESET;
      bus_tick_q.delete();
      fail_n   = 0;
      result_n = 0;
      byte_n   = 0;
      ended_n  = 0;
      nack_n   = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
          CFG_DELAY_TICKS:    delay_q  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        bus_tick_q.push_back(next_bus_tick(s_tdata[0], s_tdata[8:1], s_tdata[13:9],
                                           s_tdata[14]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3], m_tdata[11:4], m_tlast,
               m_tdata[12], m_tdata[14:13]};
        if (bus_tick_q.size() == 0) begin
          if (fail_n < MAX_REPORTS)
            $display("[%0t] result %0d arrived with nothing expected", $realtime, result_n);
          fail_n++;
        end else begin
          want = bus_tick_q.pop_front();
          if (got !== want) begin
            if (fail_n < MAX_REPORTS)
              $display({"[%0t] result %0d: expected scl %b sda %b busy %b valid %b byte %h ",
                        "last %b done %b status %0d, got scl %b sda %b busy %b valid %b ",
                        "byte %h last %b done %b status %0d"}, $realtime, result_n,
                       want.scl, want.sda, want.busy, want.valid, want.rbyte, want.last,
                       want.done, want.status, got.scl, got.sda, got.busy, got.valid,
                       got.rbyte, got.last, got.done, got.status);
            fail_n++;
          end
          if (want.valid) byte_n++;
          if (want.done) begin
            ended_n++;
            if (want.status != 2'd0) nack_n++;
          end
        end
        result_n++;
      end
    end
    mismatches      <= fail_n;
    outstanding     <= bus_tick_q.size();
    bytes_checked   <= byte_n;
    transfers_ended <= ended_n;
    nack_endings    <= nack_n;
  end

endmodule

### tb/sv/i2c_master_command_read_tb.sv
// i2c_master_command_read_tb: stimulus and verdict for the i2c register-read master
// depends on i2cmr_pkg, i2c_master_command_read and i2cmr_bus_checker
module i2c_master_command_read_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS = 1000;
  // enough idle requests at delay 1 to see out a transfer left over from the directed part
  localparam int DRAIN_TICKS  = 130;
  // receiver hold-off: the first sets after how many results it starts, the second how long it lasts
  localparam int HOLD_AFTER   = 700;
  localparam int HOLD_CYCLES  = 400;
  // segment counts of a full transfer: start 4, three written bytes of 27 with a
  // repeated start of 4 before the last, 19 per read byte, stop 3
  localparam int READ_FIRST_SEG = 89;
  localparam int READ_BYTE_SEGS = 19;
  localparam int STOP_SEGS      = 3;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // start_req, command[7:0], read_length[4:0], sda_in, pad
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;          // scl_level, sda_level, busy_res, byte_valid,
                                 // read_byte[7:0], done_res, status[1:0], pad
  logic        m_tlast;          // last_byte
  logic        cfg_wen   = 1'b0;
  logic        cfg_index = i2cmr_pkg::CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int bytes_checked;
  int transfers_ended;
  int nack_endings;
  int ticks_sent = 0;
  bit steady     = 1'b0;   // no sender gaps while set

  i2c_master_command_read dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cmr_bus_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .bytes_checked   (bytes_checked),
    .transfers_ended (transfers_ended),
    .nack_endings    (nack_endings)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly back to back, sometimes a short gap, now and then a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // segment whose last tick samples the ack of a written byte; none for reads
  function automatic int ack_seg(input i2cmr_pkg::stage_t s);
    case (s)
      i2cmr_pkg::ST_ADDR_W: return 29;
      i2cmr_pkg::ST_CMD:    return 56;
      i2cmr_pkg::ST_ADDR_R: return 87;
      default:              return -1;
    endcase
  endfunction

  // offer one request (one bus tick) and hold it until taken
  task automatic send_tick(input logic start, input logic [7:0] cmd, input logic [4:0] len,
                           input logic sda);
    int gap;
    gap = steady ? 0 : pick_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, sda, len, cmd, start};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // tick with no start and random content
  task automatic noise_tick();
    send_tick(1'b0, 8'($urandom), 5'($urandom), 1'($urandom));
  endtask

  // stop offering, let every result drain, then write one register
  task automatic write_reg(input logic idx, input logic [15:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // receiver: random stalls with calm stretches, and one long hold-off so the
  // output register fills and the request side backs up
  initial begin : receiver
    int  results;
    int  hold_left;
    int  stall_left;
    int  calm_left;
    bit  calm;
    bit  held;
    results    = 0;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (m_tvalid && m_tready) results++;
        if (!held && results >= HOLD_AFTER) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (calm_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          calm_left = 150;
        end
        calm_left--;
        if (hold_left > 0) begin
          hold_left--;
          m_tready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0]         cmd;
    logic [4:0]         len_field;
    logic [15:0]        delay_val;
    logic [6:0]         addr;
    logic               sda_bit;
    i2cmr_pkg::stage_t  nack_stage;
    int                 eff_len;
    int                 span;
    int                 segs;
    int                 seg;
    int                 r;
    int                 base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle ticks straight out of reset, the second with command, length and sda at their top
    send_tick(1'b0, 8'h00, 5'd0, 1'b0);
    send_tick(1'b0, 8'hFF, 5'h1F, 1'b1);
    // start with command all ones and length zero (taken as one) at the reset delay
    send_tick(1'b1, 8'hFF, 5'd0, 1'b0);
    // further starts while busy must be ignored
    repeat (3) send_tick(1'b1, 8'h00, 5'h1F, 1'b1);
    // zero delay behaves as one tick per segment
    write_reg(i2cmr_pkg::CFG_DELAY_TICKS, 16'd0);
    repeat (2) noise_tick();
    // address changed mid-transfer, upper data bits set; longest delay
    write_reg(i2cmr_pkg::CFG_DEVICE_ADDRESS, 16'hFF7F);
    write_reg(i2cmr_pkg::CFG_DELAY_TICKS, 16'hFFFF);
    repeat (3) noise_tick();
    // shorter delay while the segment is already past it: ends on this tick
    write_reg(i2cmr_pkg::CFG_DELAY_TICKS, 16'd2);
    repeat (2) noise_tick();
    write_reg(i2cmr_pkg::CFG_DELAY_TICKS, 16'd1);
    repeat (DRAIN_TICKS) noise_tick();

    // random transfers: mostly well-formed with acks in the right segments,
    // some cut short by a nack in one of the written bytes
    span = 1;
    base = ticks_sent;
    while (ticks_sent - base < RANDOM_TICKS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        delay_val = (r < 55) ? 16'd1 : (r < 80) ? 16'd2 : (r < 92) ? 16'd3 : 16'd0;
        write_reg(i2cmr_pkg::CFG_DELAY_TICKS, delay_val);
        span = (delay_val == 16'd0) ? 1 : int'(delay_val);
      end
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        addr = (r < 10) ? 7'd0 : (r < 20) ? 7'h7F : 7'($urandom);
        write_reg(i2cmr_pkg::CFG_DEVICE_ADDRESS, {9'($urandom), addr});
      end
      // mostly short reads, some long, a few full and a few out of range
      r = $urandom_range(0, 99);
      if (r < 70) len_field = 5'($urandom_range(1, 4));
      else if (r < 85) len_field = 5'($urandom_range(5, 15));
      else if (r < 93) len_field = 5'(i2cmr_pkg::MAX_READ_BYTES);
      else if ($urandom_range(0, 3) == 0) len_field = 5'd0;
      else len_field = 5'($urandom_range(17, 31));
      if (len_field == 5'd0) eff_len = 1;
      else if (int'(len_field) > i2cmr_pkg::MAX_READ_BYTES) eff_len = i2cmr_pkg::MAX_READ_BYTES;
      else eff_len = int'(len_field);

      r = $urandom_range(0, 99);
      nack_stage = (r < 70) ? i2cmr_pkg::ST_READ :
                   (r < 80) ? i2cmr_pkg::ST_ADDR_W :
                   (r < 90) ? i2cmr_pkg::ST_CMD : i2cmr_pkg::ST_ADDR_R;
      segs = (nack_stage == i2cmr_pkg::ST_READ)
             ? READ_FIRST_SEG + READ_BYTE_SEGS * eff_len + STOP_SEGS
             : ack_seg(nack_stage) + 2 + STOP_SEGS;
      cmd = 8'($urandom);
      for (int t = 0; t < segs * span; t++) begin
        seg = t / span;
        sda_bit = 1'($urandom);
        // target answers in the ack segments, pulling low unless it refuses here
        if (seg == ack_seg(i2cmr_pkg::ST_ADDR_W) || seg == ack_seg(i2cmr_pkg::ST_CMD) ||
            seg == ack_seg(i2cmr_pkg::ST_ADDR_R))
          sda_bit = (seg == ack_seg(nack_stage));
        if (t == 0)
          send_tick(1'b1, cmd, len_field, sda_bit);
        else
          send_tick($urandom_range(0, 7) == 0, 8'($urandom), 5'($urandom), sda_bit);
      end
      repeat ($urandom_range(0, 3)) noise_tick();
    end

    // drain and let the output register settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d bus ticks: %0d transfers finished, %0d of them on a nack",
             ticks_sent, transfers_ended, nack_endings);
    $display("checked %0d read bytes, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("i2c_master_command_read regression: pass");
    end else begin
      $display("i2c_master_command_read regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("i2c_master_command_read regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/i2cmr_pkg.sv
rtl/i2cmr_core.sv
rtl/i2c_master_command_read.sv
tb/sv/i2cmr_bus_checker.sv
tb/sv/i2c_master_command_read_tb.sv
